// File: hw/rtl/bara_pkg.sv
// Package for the barometric altitude block: beat types, fixed-point constants
// and the logarithm and exponent tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bara_pkg;

    localparam int FRAC_BITS   = 24;
    localparam int QB          = FRAC_BITS + 2;
    localparam int MW          = $clog2(QB);
    localparam int NORM_W      = QB + 30;
    localparam int CALC_STAGES = 11;
    localparam int LATENCY     = QB + CALC_STAGES + 2;
    localparam int QDEPTH      = 2;
    localparam int QPW         = $clog2(QDEPTH);
    localparam int QCW         = $clog2(QDEPTH + 1);

    localparam logic [18:0]   EXP_COEF  = 19'd199229;
    localparam logic [12:0]   T_OFFSET  = 13'd2730;
    localparam logic [10:0]   T_SCALE   = 11'd2000;
    localparam int            DIV13_SH  = 29;
    localparam longint        DIV13_M   = ((64'd1 << DIV13_SH) + 64'd12) / 64'd13;
    localparam logic [27:0]   H_OFFSET  = 28'd13631488;
    localparam logic [25:0]   F_OFFSET  = 26'd1048576;
    localparam logic [21:0]   ALT_LIMIT = 22'd2000000;

    typedef struct packed {
        logic [16:0]        pressure;
        logic signed [15:0] temperature;
        logic               sample_valid;
    } in_t;

    typedef struct packed {
        logic signed [21:0] altitude;
        logic [16:0]        pressure_out;
        logic signed [15:0] temperature_out;
        logic               valid_out;
    } out_t;

    typedef struct packed {
        in_t  smp;
        logic zero;
        logic ovf;
    } job_t;

    typedef enum logic [1:0] {
        REG_TEMP = 2'd0,
        REG_PRES = 2'd1,
        REG_ALT  = 2'd2
    } reg_idx_t;

    function automatic logic [16:0] log_tab(input logic [5:0] i);
        logic [16:0] v;
        case (i)
            6'd0:  v = 17'd0;
            6'd1:  v = 17'd2909;
            6'd2:  v = 17'd5732;
            6'd3:  v = 17'd8473;
            6'd4:  v = 17'd11136;
            6'd5:  v = 17'd13727;
            6'd6:  v = 17'd16248;
            6'd7:  v = 17'd18704;
            6'd8:  v = 17'd21098;
            6'd9:  v = 17'd23433;
            6'd10: v = 17'd25711;
            6'd11: v = 17'd27936;
            6'd12: v = 17'd30109;
            6'd13: v = 17'd32234;
            6'd14: v = 17'd34312;
            6'd15: v = 17'd36346;
            6'd16: v = 17'd38336;
            6'd17: v = 17'd40286;
            6'd18: v = 17'd42196;
            6'd19: v = 17'd44068;
            6'd20: v = 17'd45904;
            6'd21: v = 17'd47705;
            6'd22: v = 17'd49472;
            6'd23: v = 17'd51207;
            6'd24: v = 17'd52911;
            6'd25: v = 17'd54584;
            6'd26: v = 17'd56229;
            6'd27: v = 17'd57845;
            6'd28: v = 17'd59434;
            6'd29: v = 17'd60997;
            6'd30: v = 17'd62534;
            6'd31: v = 17'd64047;
            6'd32: v = 17'd65536;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [17:0] exp_tab(input logic [5:0] i);
        logic [17:0] v;
        case (i)
            6'd0:  v = 18'd65536;
            6'd1:  v = 18'd66971;
            6'd2:  v = 18'd68438;
            6'd3:  v = 18'd69936;
            6'd4:  v = 18'd71468;
            6'd5:  v = 18'd73032;
            6'd6:  v = 18'd74632;
            6'd7:  v = 18'd76266;
            6'd8:  v = 18'd77936;
            6'd9:  v = 18'd79642;
            6'd10: v = 18'd81386;
            6'd11: v = 18'd83169;
            6'd12: v = 18'd84990;
            6'd13: v = 18'd86851;
            6'd14: v = 18'd88752;
            6'd15: v = 18'd90696;
            6'd16: v = 18'd92682;
            6'd17: v = 18'd94711;
            6'd18: v = 18'd96785;
            6'd19: v = 18'd98905;
            6'd20: v = 18'd101070;
            6'd21: v = 18'd103283;
            6'd22: v = 18'd105545;
            6'd23: v = 18'd107856;
            6'd24: v = 18'd110218;
            6'd25: v = 18'd112631;
            6'd26: v = 18'd115098;
            6'd27: v = 18'd117618;
            6'd28: v = 18'd120194;
            6'd29: v = 18'd122825;
            6'd30: v = 18'd125515;
            6'd31: v = 18'd128263;
            6'd32: v = 18'd131072;
            default: v = 18'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bara_front.sv
// Front end: takes a sample beat, flags zero pressure and ratio overflow.
// Depends on bara_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bara_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire bara_pkg::in_t     sample,
    input  wire logic [16:0]       pres_base,
    input  wire logic              room,
    output logic                   busy,
    output logic                   push,
    output bara_pkg::job_t         job
);
    import bara_pkg::*;

    logic v_reg, v_next;
    job_t job_reg, job_next;
    logic accept;

    always_comb
    begin
        busy     = v_reg & ~room;
        accept   = start & ~busy;
        v_next   = accept | (v_reg & ~room);
        job_next = job_reg;
        if (accept)
        begin
            job_next.smp  = sample;
            job_next.zero = (sample.pressure == 17'd0);
            job_next.ovf  = ({2'b00, sample.pressure} >= {pres_base, 2'b00});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    assign push = v_reg;
    assign job  = job_reg;
endmodule
`default_nettype wire

// File: hw/rtl/bara_queue.sv
// Short queue between the front end and the arithmetic back end.
// Depends on bara_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bara_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire bara_pkg::job_t    in_job,
    output logic                   room,
    output logic                   out_v,
    output bara_pkg::job_t         out_job
);
    import bara_pkg::*;

    job_t mem [QDEPTH];
    logic [QPW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [QCW-1:0] cnt_reg, cnt_next;
    logic pop, wr;

    always_comb
    begin
        pop      = (cnt_reg != '0);
        room     = (cnt_reg != QCW'(QDEPTH)) | pop;
        wr       = push & room;
        wp_next  = wr ? QPW'(wp_reg + 1'b1) : wp_reg;
        rp_next  = pop ? QPW'(rp_reg + 1'b1) : rp_reg;
        cnt_next = QCW'(cnt_reg + QCW'(wr) - QCW'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= in_job;
    end

    assign out_v   = pop;
    assign out_job = mem[rp_reg];
endmodule
`default_nettype wire

// File: hw/rtl/bara_div.sv
// Pipelined restoring divider forming the pressure ratio, one quotient bit a stage.
// Depends on bara_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bara_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_v,
    input  wire bara_pkg::job_t    in_job,
    input  wire logic [16:0]       pres_base,
    output logic                   out_v,
    output bara_pkg::job_t         out_job,
    output logic [bara_pkg::QB-1:0] out_ratio
);
    import bara_pkg::*;

    logic          v_reg   [QB];
    job_t          job_reg [QB];
    logic [16:0]   r_reg   [QB];
    logic [QB-1:0] q_reg   [QB];

    logic          cv   [QB];
    job_t          cjob [QB];
    logic [16:0]   cr   [QB];
    logic [QB-1:0] cq   [QB];
    logic          nb   [QB];
    logic [16:0]   nr   [QB];
    logic [QB-1:0] nq   [QB];

    genvar s;
    generate
        for (s = 0; s < QB; s++)
        begin : g_stage
            logic [17:0] t;
            logic        ge;

            if (s == 0)
            begin : g_first
                assign cv[s]   = in_v;
                assign cjob[s] = in_job;
                assign cr[s]   = in_job.smp.pressure >> (QB - FRAC_BITS);
                assign cq[s]   = '0;
            end
            else
            begin : g_next
                assign cv[s]   = v_reg[s-1];
                assign cjob[s] = job_reg[s-1];
                assign cr[s]   = r_reg[s-1];
                assign cq[s]   = q_reg[s-1];
            end

            if (QB - 1 - s >= FRAC_BITS)
            begin : g_nbit
                assign nb[s] = cjob[s].smp.pressure[QB - 1 - s - FRAC_BITS];
            end
            else
            begin : g_zbit
                assign nb[s] = 1'b0;
            end

            always_comb
            begin
                t     = {cr[s], nb[s]};
                ge    = (t >= {1'b0, pres_base});
                nr[s] = ge ? 17'(t - {1'b0, pres_base}) : t[16:0];
                nq[s] = {cq[s][QB-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[s] <= 1'b0;
                else
                    v_reg[s] <= cv[s];
            end

            always_ff @(posedge clk)
            begin
                job_reg[s] <= cjob[s];
                r_reg[s]   <= nr[s];
                q_reg[s]   <= nq[s];
            end
        end
    endgenerate

    always_comb
    begin
        out_v   = v_reg[QB-1];
        out_job = job_reg[QB-1];
        if (job_reg[QB-1].zero)
            out_ratio = '0;
        else if (job_reg[QB-1].ovf)
            out_ratio = '1;
        else
            out_ratio = q_reg[QB-1];
    end
endmodule
`default_nettype wire

// File: hw/rtl/bara_calc.sv
// Back-end pipeline: log2 and exp2 of the ratio by table interpolation, then the
// scaled altitude with truncation and saturation. Depends on bara_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bara_calc (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_v,
    input  wire bara_pkg::in_t           in_smp,
    input  wire logic [bara_pkg::QB-1:0] ratio,
    input  wire logic signed [11:0]      temp_base,
    input  wire logic signed [20:0]      alt_base,
    output logic                         done,
    output bara_pkg::out_t               result
);
    import bara_pkg::*;

    logic vp_reg [CALC_STAGES];
    in_t  sp_reg [CALC_STAGES-1];
    logic pz_reg [5];

    logic [MW-1:0]       m_c, m1_reg, m2_reg;
    logic [NORM_W-1:0]   wide_c;
    logic [29:0]         f1_reg;
    logic [16:0]         lbase_c, lnext_c, lbase2_reg;
    logic [11:0]         ldiff_c, lint2_reg;
    logic [36:0]         lprod_c;
    logic [7:0]          e_c;
    logic signed [23:0]  lg3_reg, lg_c;
    logic signed [42:0]  ym4_reg;
    logic signed [22:0]  y_c;
    logic signed [6:0]   k5_reg;
    logic [17:0]         ebase_c, enext_c, ebase5_reg;
    logic [11:0]         ediff_c, eint5_reg;
    logic [22:0]         eprod_c;
    logic [17:0]         ev_c;
    logic [31:0]         p_c, pw_c;
    logic [6:0]          sh_c;
    logic signed [32:0]  d6_reg;
    logic [12:0]         ts_c;
    logic [23:0]         tsk_reg;
    logic signed [57:0]  x7_reg;
    logic [24:0]         hp8_reg, hp9_reg;
    logic                low8_reg, low9_reg;
    logic [50:0]         qm9_reg;
    logic [21:0]         q10_reg;
    logic [25:0]         rm_c;
    logic                nz10_reg;
    logic signed [25:0]  f_c, alt_c;
    out_t                res_reg, res_c;

    always_comb
    begin
        m_c = '0;
        for (int i = 0; i < QB; i++)
        begin
            if (ratio[i])
                m_c = MW'(i);
        end
        wide_c = {ratio, 30'b0} >> m_c;

        lbase_c = log_tab({1'b0, f1_reg[29:25]});
        lnext_c = log_tab(6'({1'b0, f1_reg[29:25]} + 6'd1));
        ldiff_c = 12'(lnext_c - lbase_c);
        lprod_c = 37'(ldiff_c) * 37'(f1_reg[24:0]);

        e_c  = 8'({3'b000, m2_reg}) - 8'(FRAC_BITS);
        lg_c = $signed({e_c, 16'b0}) + $signed({7'b0, lbase2_reg})
             + $signed({12'b0, lint2_reg});

        y_c     = ym4_reg[42:20];
        ebase_c = exp_tab({1'b0, y_c[15:11]});
        enext_c = exp_tab(6'({1'b0, y_c[15:11]} + 6'd1));
        ediff_c = 12'(enext_c - ebase_c);
        eprod_c = 23'(ediff_c) * 23'(y_c[10:0]);

        ev_c = 18'(ebase5_reg + 18'(eint5_reg));
        p_c  = {ev_c, 14'b0};
        sh_c = k5_reg[6] ? 7'(-k5_reg) : 7'd0;
        pw_c = pz_reg[4] ? 32'd0 : (p_c >> sh_c);

        ts_c = 13'($signed(13'(temp_base)) + $signed({1'b0, T_OFFSET[11:0]}));

        rm_c = {1'b0, hp9_reg} - 26'(26'(qm9_reg[50:29]) * 26'd13);

        f_c   = $signed(26'(alt_base)) + $signed({4'b0, q10_reg}) - $signed(F_OFFSET);
        alt_c = f_c + ((f_c < 0 && nz10_reg) ? 26'sd1 : 26'sd0);
        res_c.pressure_out    = sp_reg[CALC_STAGES-2].pressure;
        res_c.temperature_out = sp_reg[CALC_STAGES-2].temperature;
        res_c.valid_out       = sp_reg[CALC_STAGES-2].sample_valid;
        if (alt_c > $signed({4'b0, ALT_LIMIT}))
            res_c.altitude = $signed(ALT_LIMIT);
        else if (alt_c < -$signed({4'b0, ALT_LIMIT}))
            res_c.altitude = -$signed(ALT_LIMIT);
        else
            res_c.altitude = alt_c[21:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CALC_STAGES; i++)
                vp_reg[i] <= 1'b0;
        end
        else
        begin
            vp_reg[0] <= in_v;
            for (int i = 1; i < CALC_STAGES; i++)
                vp_reg[i] <= vp_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        sp_reg[0] <= in_smp;
        for (int i = 1; i < CALC_STAGES - 1; i++)
            sp_reg[i] <= sp_reg[i-1];
        pz_reg[0] <= (ratio == '0);
        for (int i = 1; i < 5; i++)
            pz_reg[i] <= pz_reg[i-1];

        m1_reg     <= m_c;
        f1_reg     <= wide_c[29:0];
        m2_reg     <= m1_reg;
        lbase2_reg <= lbase_c;
        lint2_reg  <= lprod_c[36:25];
        lg3_reg    <= lg_c;
        ym4_reg    <= 43'(lg3_reg) * $signed({24'b0, EXP_COEF});
        k5_reg     <= y_c[22:16];
        ebase5_reg <= ebase_c;
        eint5_reg  <= eprod_c[22:11];
        d6_reg     <= $signed(33'h040000000) - $signed({1'b0, pw_c});
        tsk_reg    <= 24'(24'(ts_c) * 24'(T_SCALE));
        x7_reg     <= $signed({34'b0, tsk_reg}) * 58'(d6_reg);
        hp8_reg    <= 25'(x7_reg[57:30] + $signed(H_OFFSET));
        low8_reg   <= |x7_reg[29:0];
        hp9_reg    <= hp8_reg;
        low9_reg   <= low8_reg;
        qm9_reg    <= 51'(hp8_reg) * 51'(DIV13_M);
        q10_reg    <= qm9_reg[50:29];
        nz10_reg   <= low9_reg | (rm_c[3:0] != 4'd0);
        res_reg    <= res_c;
    end

    assign done   = vp_reg[CALC_STAGES-1];
    assign result = res_reg;
endmodule
`default_nettype wire

// File: hw/rtl/barometric_altitude.sv
// Top level of the barometric altitude block: configuration registers, front end,
// queue, ratio divider and altitude pipeline. Depends on bara_pkg and the bara_ modules it instantiates.
`timescale 1ns / 1ps
`default_nettype none
// One sample beat is taken per clock, and each gives one result beat, marked by
// done for a single cycle; the result must be captured then, as it is not held.
// The path runs through a register in the front end, one in the queue, the
// 26-stage ratio divider with one quotient bit per stage and eleven stages of
// table interpolation and scaling. The back end takes a beat every cycle, so
// busy never rises.
// Registers: 0 reference temperature, 1 reference pressure, 2 reference altitude;
// write them only while no sample is in flight.
module barometric_altitude (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire bara_pkg::in_t    sample,
    output logic                  done,
    output bara_pkg::out_t        result,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [20:0]      cfg_data
);
    import bara_pkg::*;

    logic signed [11:0] temp_base_reg;
    logic [16:0]        pres_base_reg;
    logic signed [20:0] alt_base_reg;

    logic          push, room, qv, dv;
    job_t          fjob, qjob, djob;
    logic [QB-1:0] ratio;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_base_reg <= 12'sd150;
            pres_base_reg <= 17'd101300;
            alt_base_reg  <= 21'sd0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_TEMP: temp_base_reg <= cfg_data[11:0];
                REG_PRES: pres_base_reg <= cfg_data[16:0];
                REG_ALT:  alt_base_reg  <= cfg_data[20:0];
                default:  ;
            endcase
        end
    end

    bara_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .sample    (sample),
        .pres_base (pres_base_reg),
        .room      (room),
        .busy      (busy),
        .push      (push),
        .job       (fjob)
    );

    bara_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .in_job  (fjob),
        .room    (room),
        .out_v   (qv),
        .out_job (qjob)
    );

    bara_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_v      (qv),
        .in_job    (qjob),
        .pres_base (pres_base_reg),
        .out_v     (dv),
        .out_job   (djob),
        .out_ratio (ratio)
    );

    bara_calc u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_v      (dv),
        .in_smp    (djob.smp),
        .ratio     (ratio),
        .temp_base (temp_base_reg),
        .alt_base  (alt_base_reg),
        .done      (done),
        .result    (result)
    );
endmodule
`default_nettype wire

// File: hw/rtl/bara_chk.sv
// Port-level checker for the barometric altitude block, bound to the top level.
// Depends on bara_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bara_chk (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire bara_pkg::in_t    sample,
    input wire logic             done,
    input wire bara_pkg::out_t   result,
    input wire logic             cfg_we,
    input wire logic [1:0]       cfg_index,
    input wire logic [20:0]      cfg_data
);
    import bara_pkg::*;

    a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (!busy ##LATENCY done))
        else $error("offered beat stalled or gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LATENCY !done)
        else $error("result without a beat");

    a_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY
            (result.pressure_out == $past(sample.pressure, LATENCY)
             && result.temperature_out == $past(sample.temperature, LATENCY)))
        else $error("pass-through fields corrupted");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.altitude <= $signed(ALT_LIMIT)
                  && result.altitude >= -$signed(ALT_LIMIT)))
        else $error("altitude out of range");

    a_cfg_known: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> !$isunknown({cfg_index, cfg_data}))
        else $error("configuration write with unknown index or data");
endmodule

bind barometric_altitude bara_chk u_chk (.*);
`default_nettype wire

// File: tb/sv/tb_barometric_altitude.sv
// Testbench for the barometric altitude block: drives sample beats and register writes,
// predicts every result beat in fixed point and checks it. Depends on bara_pkg and the RTL.
`timescale 1ns / 1ps
module tb_barometric_altitude;
    import bara_pkg::*;

    localparam int WATCH_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    in_t         sample = '0;
    logic        done;
    out_t        result;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [20:0] cfg_data = '0;

    barometric_altitude dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic [11:0] t_ref = 12'd150;
    logic [16:0] p_ref = 17'd101300;
    logic [20:0] a_ref = 21'd0;

    in_t  pending_samples[$];
    out_t expected_beats[$];
    int   errors = 0;
    int   idle_cycles = 0;
    int   gap = 0;
    bit   hold_off = 1'b0;

    function automatic longint fdiv_pow2(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-v + (64'sd1 << s) - 1) >>> s);
    endfunction

    function automatic longint log_val(longint i);
        longint t[33] = '{0, 2909, 5732, 8473, 11136, 13727, 16248, 18704,
            21098, 23433, 25711, 27936, 30109, 32234, 34312, 36346, 38336, 40286,
            42196, 44068, 45904, 47705, 49472, 51207, 52911, 54584, 56229, 57845,
            59434, 60997, 62534, 64047, 65536};
        return t[i];
    endfunction

    function automatic longint exp_val(longint i);
        longint t[33] = '{65536, 66971, 68438, 69936, 71468, 73032, 74632, 76266,
            77936, 79642, 81386, 83169, 84990, 86851, 88752, 90696, 92682, 94711,
            96785, 98905, 101070, 103283, 105545, 107856, 110218, 112631, 115098,
            117618, 120194, 122825, 125515, 128263, 131072};
        return t[i];
    endfunction

    function automatic longint power_of_ratio(longint r);
        int m;
        longint n, f, idx, rem, lf, lg, y, k, g, ev, p;
        if (r == 0)
            return 0;
        m = 63;
        while (m > 0 && r[m] == 1'b0)
            m--;
        n = (m >= 30) ? (r >> (m - 30)) : (r << (30 - m));
        f = n - (64'sd1 << 30);
        idx = (f >> 25) & 31;
        rem = f & ((64'sd1 << 25) - 1);
        lf = log_val(idx) + (((log_val(idx + 1) - log_val(idx)) * rem) >> 25);
        lg = (m - FRAC_BITS) * 65536 + lf;
        y = fdiv_pow2(lg * 199229, 20);
        k = fdiv_pow2(y, 16);
        g = (y - k * 65536) & 16'hFFFF;
        idx = g >> 11;
        rem = g & 2047;
        ev = exp_val(idx) + (((exp_val(idx + 1) - exp_val(idx)) * rem) >> 11);
        p = ev << 14;
        if (k >= 0)
            return p;
        if (-k > 40)
            return 0;
        return p >> (-k);
    endfunction

    function automatic out_t altitude_of(in_t s);
        out_t o;
        longint rmax, ratio, pw, ts, ra, num, den, alt;
        rmax = (64'sd4 << FRAC_BITS) - 1;
        if (s.pressure == 0)
            ratio = 0;
        else if (p_ref == 0)
            ratio = rmax;
        else
        begin
            ratio = (longint'(s.pressure) << FRAC_BITS) / longint'(p_ref);
            if (ratio > rmax)
                ratio = rmax;
        end
        pw = power_of_ratio(ratio);
        ts = longint'($signed(t_ref)) + 2730;
        ra = longint'($signed(a_ref));
        den = 64'sd13 << 30;
        num = ra * den + ts * 2000 * ((64'sd1 << 30) - pw);
        alt = num / den;
        if (alt > 2000000)
            alt = 2000000;
        if (alt < -2000000)
            alt = -2000000;
        o.altitude = alt[21:0];
        o.pressure_out = s.pressure;
        o.temperature_out = s.temperature;
        o.valid_out = s.sample_valid;
        return o;
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // Driver: one sample beat per accepted start; the prediction is made at acceptance.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                expected_beats.push_back(altitude_of(sample));
            if (start && busy)
                ;
            else if (gap > 0 || hold_off || pending_samples.size() == 0)
            begin
                start <= 1'b0;
                if (gap > 0)
                    gap <= gap - 1;
            end
            else
            begin
                start <= 1'b1;
                sample <= pending_samples.pop_front();
                gap <= random_gap();
            end
        end
    end

    // Monitor: every done beat is matched against the oldest prediction.
    always @(posedge clk)
    begin
        out_t e;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (done)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected result beat %p", result);
                    errors++;
                end
                else
                begin
                    e = expected_beats.pop_front();
                    if (result.altitude !== e.altitude)
                    begin
                        $error("altitude exp %0d got %0d", e.altitude, result.altitude);
                        errors++;
                    end
                    if (result.pressure_out !== e.pressure_out)
                    begin
                        $error("pressure_out exp %0d got %0d", e.pressure_out,
                            result.pressure_out);
                        errors++;
                    end
                    if (result.temperature_out !== e.temperature_out)
                    begin
                        $error("temperature_out exp %0d got %0d", e.temperature_out,
                            result.temperature_out);
                        errors++;
                    end
                    if (result.valid_out !== e.valid_out)
                    begin
                        $error("valid_out exp %0d got %0d", e.valid_out, result.valid_out);
                        errors++;
                    end
                end
            end
            if (idle_cycles > WATCH_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic drain();
        while (pending_samples.size() != 0 || start || expected_beats.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [20:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TEMP: t_ref = value[11:0];
            REG_PRES: p_ref = value[16:0];
            default:  a_ref = value;
        endcase
    endtask

    function automatic in_t random_sample(logic [16:0] pref);
        in_t s;
        s.temperature = 16'($urandom());
        s.sample_valid = 1'($urandom());
        case ($urandom_range(0, 9))
            0: s.pressure = 17'($urandom());
            1: s.pressure = 17'($urandom_range(0, 8));
            2: s.pressure = 17'(17'h1FFFF - $urandom_range(0, 8));
            default:
                s.pressure = (pref == 0) ? 17'($urandom()) :
                    17'($urandom_range(pref / 4, (pref > 65535) ? 131071 : pref * 2));
        endcase
        return s;
    endfunction

    task automatic add_directed();
        in_t s;
        logic [16:0] plist[8] = '{17'd0, 17'd1, 17'h1FFFF, 17'd101300, 17'd50000,
            17'd30000, 17'd101299, 17'd65536};
        foreach (plist[i])
        begin
            s.pressure = plist[i];
            s.temperature = (i % 2) ? 16'sh7FFF : -16'sh8000;
            s.sample_valid = i[0];
            pending_samples.push_back(s);
        end
    endtask

    initial
    begin
        logic [11:0] temps[5] = '{12'd150, -12'sd1000, 12'd1500, 12'd0, -12'sd273};
        logic [16:0] press[5] = '{17'd101300, 17'd1, 17'd131071, 17'd0, 17'd50000};
        logic [20:0] alts[5] = '{21'd0, -21'sd100000, 21'd1000000, 21'h0FFFFF, 21'h100000};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        add_directed();
        drain();
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph < 5)
            begin
                write_reg(REG_TEMP, 21'($signed(temps[ph])));
                write_reg(REG_PRES, 21'(press[ph]));
                write_reg(REG_ALT, alts[ph]);
            end
            else
            begin
                write_reg(REG_TEMP, 21'($urandom_range(0, 2500)) - 21'd1000);
                write_reg(REG_PRES, 21'($urandom_range(1, 131071)));
                write_reg(REG_ALT, 21'($urandom_range(0, 1100000)) - 21'd100000);
            end
            if (ph == 2)
                add_directed();
            for (int i = 0; i < 160; i++)
                pending_samples.push_back(random_sample(p_ref));
            if (ph == 6)
            begin
                // Hold the sender until the pipeline is empty, then carry on.
                while (pending_samples.size() > 80)
                    @(posedge clk);
                hold_off = 1'b1;
                while (start || expected_beats.size() != 0)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            drain();
        end
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: barometric_altitude.f
hw/rtl/bara_pkg.sv
hw/rtl/bara_front.sv
hw/rtl/bara_queue.sv
hw/rtl/bara_div.sv
hw/rtl/bara_calc.sv
hw/rtl/barometric_altitude.sv
hw/rtl/bara_chk.sv
tb/sv/tb_barometric_altitude.sv
